>>> rtl/core/ffba_pkg.sv
// ffba_pkg: shared constants and types of the first-fit block allocator
// no dependencies; used by first_fit_block_allocator

package ffba_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
  localparam int OFF_W       = 25;
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 24;
  localparam int HDR_W       = 8;
  localparam int ALIGN_BYTES = 8;

  localparam logic [OFF_W-1:0] ALIGN_MASK = OFF_W'(ALIGN_BYTES - 1);
  localparam logic [OFF_W-1:0] LIMIT_RST  = OFF_W'(1048576);
  localparam logic [HDR_W-1:0] HDR_RST    = HDR_W'(32);

  // register indexes of the configuration port
  localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT   = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [OFF_W-1:0] length;
    logic             is_free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/ffba_ram.sv
// ffba_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// first_fit_block_allocator: top level, block table walk and append logic
// depends on ffba_pkg and ffba_ram
//
// usage: one input word per request. op_i selects allocate (request_size_i)
// or free (user_address_i). every request yields exactly one result word
// with granted_address_o and status_o. both channels use valid/stall; a word
// moves at an edge with valid high and stall low.
// configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. write only while no request is in flight.
// walk: a request walks the block table one entry per cycle out of a
// single RAM with registered read data; an allocate that finds no fitting
// entry then takes the append step, and every request ends with the output
// load. zero size, free of address zero and any request on an empty table
// skip the walk.
// throughput: one request at a time; the next request is taken in the
// cycle after the result is loaded. in_stall_o is high while a request
// is being worked on.
// a finished result sits in the output register; a new request is taken
// while it waits. if the receiver stalls, the next result waits inside.
// reset: table count and break pointer clear at once, no clearing pass;
// the registers take their reset values.

module first_fit_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [23:0] request_size_i,
  input  logic [31:0] user_address_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] granted_address_o,
  output logic [1:0]  status_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  localparam int OFF_W  = ffba_pkg::OFF_W;
  localparam int ADDR_W = ffba_pkg::ADDR_W;
  localparam int CNT_W  = ffba_pkg::CNT_W;
  localparam int IDX_W  = ffba_pkg::IDX_W;
  localparam int HDR_W  = ffba_pkg::HDR_W;
  localparam int END_W  = OFF_W + 2;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] heap_base_q;
  logic [OFF_W-1:0]  heap_limit_q;
  logic [HDR_W-1:0]  header_bytes_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [OFF_W-1:0]  break_q, break_d;

  logic              op_q, op_d;
  logic [OFF_W-1:0]  size_q, size_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              chk_vld_q, chk_vld_d;
  logic [CNT_W-1:0]  chk_idx_q, chk_idx_d;

  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [1:0]        res_status_q, res_status_d;

  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [1:0]        out_status_q, out_status_d;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr;
  ffba_pkg::entry_t      ram_wentry, ram_rentry;
  logic [ffba_pkg::ENTRY_W-1:0] ram_rdata;

  logic              in_fire, out_fire, out_free;
  logic [OFF_W-1:0]  size_rounded;
  logic [ADDR_W-1:0] entry_uaddr;
  logic              entry_hit;
  logic              last_chk;
  logic [END_W-1:0]  tail_hdr, tail_end;
  logic [OFF_W-1:0]  tail_start;
  logic              tail_fail;

  assign cfg_ready_o = 1'b1;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // round up to the alignment, 24-bit request never overflows 25 bits
  assign size_rounded = (OFF_W'(request_size_i) + ffba_pkg::ALIGN_MASK) & ~ffba_pkg::ALIGN_MASK;

  assign ram_rentry  = ffba_pkg::entry_t'(ram_rdata);
  assign entry_uaddr = heap_base_q + ADDR_W'(ram_rentry.start);
  assign entry_hit   = chk_vld_q && ((op_q == ffba_pkg::OP_ALLOC)
                     ? (ram_rentry.is_free && (ram_rentry.length >= size_q))
                     : (entry_uaddr == addr_q));
  assign last_chk    = chk_vld_q && (chk_idx_q == count_q - CNT_W'(1));

  assign tail_hdr   = END_W'(break_q) + END_W'(header_bytes_q);
  assign tail_end   = tail_hdr + END_W'(size_q);
  assign tail_start = tail_hdr[OFF_W-1:0];
  assign tail_fail  = (count_q == CNT_W'(ffba_pkg::MAX_BLOCKS))
                   || (tail_end > END_W'(heap_limit_q));

  assign ram_re = (state_q == S_SCAN) && (rd_ptr_q < count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    break_d      = break_q;
    op_d         = op_q;
    size_d       = size_q;
    addr_d       = addr_q;
    rd_ptr_d     = rd_ptr_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q[IDX_W-1:0];
    ram_wentry   = ram_rentry;

    out_valid_d  = out_fire ? 1'b0 : out_valid_q;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d       = op_i;
          size_d     = size_rounded;
          addr_d     = user_address_i;
          rd_ptr_d   = '0;
          res_addr_d = '0;
          if (op_i == ffba_pkg::OP_ALLOC && request_size_i == '0) begin
            res_status_d = ffba_pkg::ST_ZERO;
            state_d      = S_DONE;
          end else if (op_i == ffba_pkg::OP_FREE && user_address_i == '0) begin
            res_status_d = ffba_pkg::ST_OK;
            state_d      = S_DONE;
          end else if (count_q == '0) begin
            if (op_i == ffba_pkg::OP_ALLOC) begin
              state_d = S_TAIL;
            end else begin
              res_status_d = ffba_pkg::ST_BADFREE;
              state_d      = S_DONE;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read of entry rd_ptr issued now, entry chk_idx checked from RAM data
        if (ram_re) begin
          rd_ptr_d  = rd_ptr_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = rd_ptr_q;
        end
        if (entry_hit) begin
          chk_vld_d          = 1'b0;
          ram_we             = 1'b1;
          ram_wentry.is_free = (op_q == ffba_pkg::OP_FREE);
          res_addr_d         = (op_q == ffba_pkg::OP_ALLOC) ? entry_uaddr : '0;
          res_status_d       = ffba_pkg::ST_OK;
          state_d            = S_DONE;
        end else if (last_chk) begin
          chk_vld_d = 1'b0;
          if (op_q == ffba_pkg::OP_ALLOC) begin
            state_d = S_TAIL;
          end else begin
            res_status_d = ffba_pkg::ST_BADFREE;
            state_d      = S_DONE;
          end
        end
      end
      S_TAIL: begin
        if (tail_fail) begin
          res_status_d = ffba_pkg::ST_NOSPACE;
        end else begin
          ram_we             = 1'b1;
          ram_waddr          = count_q[IDX_W-1:0];
          ram_wentry.start   = tail_start;
          ram_wentry.length  = size_q;
          ram_wentry.is_free = 1'b0;
          count_d            = count_q + CNT_W'(1);
          break_d            = tail_end[OFF_W-1:0];
          res_addr_d         = heap_base_q + ADDR_W'(tail_start);
          res_status_d       = ffba_pkg::ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      heap_base_q    <= '0;
      heap_limit_q   <= ffba_pkg::LIMIT_RST;
      header_bytes_q <= ffba_pkg::HDR_RST;
      count_q        <= '0;
      break_q        <= '0;
      rd_ptr_q       <= '0;
      chk_vld_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      break_q     <= break_d;
      rd_ptr_q    <= rd_ptr_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ffba_pkg::REG_HEAP_BASE:    heap_base_q    <= cfg_data_i;
          ffba_pkg::REG_HEAP_LIMIT:   heap_limit_q   <= cfg_data_i[OFF_W-1:0];
          ffba_pkg::REG_HEADER_BYTES: header_bytes_q <= cfg_data_i[HDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    chk_idx_q    <= chk_idx_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_addr_q   <= out_addr_d;
    out_status_q <= out_status_d;
  end

  ffba_ram #(
    .WIDTH (ffba_pkg::ENTRY_W),
    .DEPTH (ffba_pkg::MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ffba_pkg::MAX_BLOCKS))
    else $error("block count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
    else $error("block count moved by more than one");

  a_break_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> break_q >= $past(break_q))
    else $error("break pointer went backwards");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN) || (state_q == S_TAIL))
    else $error("table written outside walk or append");

  a_err_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ffba_pkg::ST_OK) |-> granted_address_o == '0)
    else $error("failed request carries an address");

endmodule
